// ----- design/ata_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ata_pkg;

    // Fixed-point widths of the datapath
    localparam int SQ_W    = 32;   // square of a 16-bit axis, nonnegative
    localparam int RAD_W   = 48;   // radicand: sum of squares with 16 zero bits below
    localparam int ROOT_W  = 24;   // floor root of the radicand
    localparam int REM_W   = 26;   // running remainder of the root
    localparam int VEC_W   = 28;   // CORDIC vector components
    localparam int ACC_W   = 25;   // angle accumulator, degrees times 65536
    localparam int NUM_W   = 25;   // numerator, axis times 256
    localparam int ACC_FRAC_BITS = 16;
    localparam int CORDIC_STEPS  = 20;
    localparam int SQRT_STEPS    = ROOT_W;
    // sum stage, root stages, rotation stages
    localparam int LANE_DEPTH    = 1 + SQRT_STEPS + CORDIC_STEPS;

    // atan(2^-i) in degrees times 65536, rounded to nearest
    localparam logic signed [ACC_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304,  25'sd58666,   25'sd29335,  25'sd14668,  25'sd7334,
        25'sd3667,    25'sd1833,    25'sd917,    25'sd458,    25'sd229,
        25'sd115,     25'sd57,      25'sd29,     25'sd14,     25'sd7
    };

endpackage

`default_nettype wire

// ----- design/ata_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ata_lane
    import ata_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_en,
    input  wire [SQ_W-1:0]          i_sq_p,
    input  wire [SQ_W-1:0]          i_sq_q,
    input  wire signed [NUM_W-1:0]  i_num,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_zero
);

    logic [RAD_W-1:0]          r_rad  [0:SQRT_STEPS];
    logic [REM_W-1:0]          r_rem  [0:SQRT_STEPS];
    logic [ROOT_W-1:0]         r_root [0:SQRT_STEPS];
    logic signed [NUM_W-1:0]   r_num  [0:SQRT_STEPS];
    logic                      r_zero [0:LANE_DEPTH-1];
    logic signed [VEC_W-1:0]   r_d    [0:CORDIC_STEPS-1];
    logic signed [VEC_W-1:0]   r_n    [0:CORDIC_STEPS-1];
    logic signed [ACC_W-1:0]   r_acc  [0:CORDIC_STEPS-1];

    // Sum the squares and form the radicand
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= {i_sq_p + i_sq_q, 16'd0};
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_num[0]  <= i_num;
            r_zero[0] <= (i_num == '0);
        end
    end

    // Root: one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [REM_W+1:0] w_rem2;
        logic [REM_W+1:0] w_trial;
        logic             w_ge;
        always_comb begin
            w_rem2  = {r_rem[k], r_rad[k][RAD_W-1 -: 2]};
            w_trial = {2'b00, r_root[k], 2'b01};
            w_ge    = (w_rem2 >= w_trial);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {r_rad[k][RAD_W-3:0], 2'b00};
                r_rem[k+1]  <= w_ge ? REM_W'(w_rem2 - w_trial) : REM_W'(w_rem2);
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], w_ge};
                r_num[k+1]  <= r_num[k];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    // Vectoring rotations, one step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [VEC_W-1:0] w_d;
        logic signed [VEC_W-1:0] w_n;
        logic signed [ACC_W-1:0] w_acc;
        if (i == 0) begin : g_first
            always_comb begin
                w_d   = VEC_W'($signed({1'b0, r_root[SQRT_STEPS]}));
                w_n   = VEC_W'(r_num[SQRT_STEPS]);
                w_acc = '0;
            end
        end else begin : g_next
            always_comb begin
                w_d   = r_d[i-1];
                w_n   = r_n[i-1];
                w_acc = r_acc[i-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_n > 0) begin
                    r_d[i]   <= w_d + (w_n >>> i);
                    r_n[i]   <= w_n - (w_d >>> i);
                    r_acc[i] <= w_acc + ATAN_TABLE[i];
                end else begin
                    r_d[i]   <= w_d - (w_n >>> i);
                    r_n[i]   <= w_n + (w_d >>> i);
                    r_acc[i] <= w_acc - ATAN_TABLE[i];
                end
                r_zero[SQRT_STEPS+1+i] <= r_zero[SQRT_STEPS+i];
            end
        end
    end

    assign o_acc  = r_acc[CORDIC_STEPS-1];
    assign o_zero = r_zero[LANE_DEPTH-1];

endmodule

`default_nettype wire

// ----- design/accel_tilt_angles.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// sample    i_valid / o_stall      i_sample_x, i_sample_y, i_sample_z
// angles    o_valid / i_stall      o_roll_angle, o_pitch_angle
// config    i_cfg_valid / o_cfg_ready  i_cfg_angle_limit
//
// One sample per cycle unless stalled; stages are squares, sum, 24 root stages,
// 20 rotation stages, then round and clamp.
// Synchronous active-low reset clears the valid bits and loads a 45 degree limit.
// A stalled output freezes the whole pipeline; o_stall is high exactly then.
module accel_tilt_angles
    import ata_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire signed [15:0]  i_sample_x,
    input  wire signed [15:0]  i_sample_y,
    input  wire signed [15:0]  i_sample_z,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [14:0]         i_cfg_angle_limit
);

    localparam int RND_SHIFT = ACC_FRAC_BITS - ANGLE_FRAC_BITS;
    localparam logic [14:0] LIMIT_RESET = 15'(45 << ANGLE_FRAC_BITS);
    localparam int DEPTH = 1 + LANE_DEPTH;

    logic              w_en;
    logic [14:0]       r_limit;
    logic [DEPTH-1:0]  r_valid;
    logic              r_out_valid;
    logic [SQ_W-1:0]   r_sq_x, r_sq_y, r_sq_z;
    logic signed [NUM_W-1:0] r_num_roll, r_num_pitch;
    logic signed [ACC_W-1:0] w_acc_roll, w_acc_pitch;
    logic              w_zero_roll, w_zero_pitch;
    logic signed [15:0] r_roll, r_pitch;

    assign w_en        = !(r_out_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;

    // Hold the clamp limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_angle_limit;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_valid     <= {r_valid[DEPTH-2:0], i_valid};
            r_out_valid <= r_valid[DEPTH-1];
        end
    end

    // Square the axes at full width and form the numerators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_x      <= SQ_W'(SQ_W'(i_sample_x) * SQ_W'(i_sample_x));
            r_sq_y      <= SQ_W'(SQ_W'(i_sample_y) * SQ_W'(i_sample_y));
            r_sq_z      <= SQ_W'(SQ_W'(i_sample_z) * SQ_W'(i_sample_z));
            r_num_roll  <= NUM_W'(i_sample_y) <<< 8;
            r_num_pitch <= (-NUM_W'(i_sample_x)) <<< 8;
        end
    end

    ata_lane u_roll (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sq_p (r_sq_x),
        .i_sq_q (r_sq_z),
        .i_num  (r_num_roll),
        .o_acc  (w_acc_roll),
        .o_zero (w_zero_roll)
    );

    ata_lane u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_sq_p (r_sq_y),
        .i_sq_q (r_sq_z),
        .i_num  (r_num_pitch),
        .o_acc  (w_acc_pitch),
        .o_zero (w_zero_pitch)
    );

    function automatic logic signed [15:0] round_clamp(
        input logic signed [ACC_W-1:0] acc,
        input logic                    zero,
        input logic [14:0]             limit
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rnd;
        logic [ACC_W-1:0] lim;
        mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        rnd = (mag + ACC_W'(1 << (RND_SHIFT - 1))) >> RND_SHIFT;
        lim = ACC_W'(limit);
        if (rnd > lim) rnd = lim;
        if (zero) begin
            return '0;
        end else if (acc[ACC_W-1]) begin
            return 16'(-rnd);
        end else begin
            return 16'(rnd);
        end
    endfunction

    // Round and clamp into the output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll  <= round_clamp(w_acc_roll, w_zero_roll, r_limit);
            r_pitch <= round_clamp(w_acc_pitch, w_zero_pitch, r_limit);
        end
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

// Scoreboard: predicts tilt angles for each accepted sample and checks results in order
class tilt_scoreboard;
    logic [14:0]        limit;
    logic signed [15:0] want_roll [$];
    logic signed [15:0] want_pitch [$];
    int                 errors;

    function new();
        limit  = 15'd11520;
        errors = 0;
    endfunction

    // Floor square root of a 48-bit radicand, bit by bit
    static function longint unsigned floor_root(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC on (root, a*256), rounded and clamped
    function logic signed [15:0] tilt(longint a, longint p, longint q);
        longint          vx, vy, acc, sx, sy, mag;
        longint unsigned rad;
        rad = longint'(p * p + q * q) << 16;
        vx  = longint'(floor_root(rad));
        vy  = a * 256;
        acc = 0;
        if (vy == 0) return 16'sd0;
        for (int i = 0; i < ata_pkg::CORDIC_STEPS; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy > 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + longint'(ata_pkg::ATAN_TABLE[i]);
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - longint'(ata_pkg::ATAN_TABLE[i]);
            end
        end
        mag = acc < 0 ? -acc : acc;
        mag = (mag + 128) >>> 8;
        if (mag > longint'(limit)) mag = longint'(limit);
        return acc < 0 ? 16'(-mag) : 16'(mag);
    endfunction

    // Note an accepted sample
    function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        want_roll.push_back(tilt(longint'(y), longint'(x), longint'(z)));
        want_pitch.push_back(tilt(-longint'(x), longint'(y), longint'(z)));
    endfunction

    // Check one accepted result against the oldest prediction
    function void check_angles(logic signed [15:0] roll, logic signed [15:0] pitch);
        logic signed [15:0] er, ep;
        if (want_roll.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result roll=%0d pitch=%0d", roll, pitch);
            return;
        end
        er = want_roll.pop_front();
        ep = want_pitch.pop_front();
        if (roll !== er || pitch !== ep) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                         er, roll, ep, pitch);
        end
    endfunction
endclass

module testbench;
    import ata_pkg::*;

    logic               i_clk, i_rst_n;
    logic               i_valid, i_stall, i_cfg_valid;
    logic signed [15:0] i_sample_x, i_sample_y, i_sample_z;
    logic [14:0]        i_cfg_angle_limit;
    wire                o_stall, o_valid, o_cfg_ready;
    wire signed [15:0]  o_roll_angle, o_pitch_angle;

    tilt_scoreboard sb = new();
    int  send_idle_pct, recv_stall_pct, hold_off;
    bit  done;

    accel_tilt_angles DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_x(i_sample_x), .i_sample_y(i_sample_y), .i_sample_z(i_sample_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_angle_limit(i_cfg_angle_limit)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    // Sample results and drive the receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_angles(o_roll_angle, o_pitch_angle);
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one sample, optionally idling first, until accepted
    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_sample_x <= x;
        i_sample_y <= y;
        i_sample_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(x, y, z);
        @(negedge i_clk);
    endtask

    // Drop valid, drain all predictions, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.want_roll.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [14:0] lim);
        i_cfg_valid       <= 1'b1;
        i_cfg_angle_limit <= lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.limit = lim;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random sample: mostly gravity-like, sometimes extremes, zeros or full-range values
    task automatic random_sample();
        logic signed [15:0] v [3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(7))
                0: v[k] = 16'sd0;
                1: v[k] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                2: v[k] = 16'($urandom_range(65535));
                default: v[k] = 16'($signed(16'($urandom_range(16384))) - 16'sd8192);
            endcase
        end
        send_sample(v[0], v[1], v[2]);
    endtask

    initial begin
        logic [14:0] limits [6];
        limits = '{15'd23040, 15'd0, 15'd32767, 15'd1, 15'd5000, 15'd11520};
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0; i_cfg_valid = 1'b0;
        i_sample_x = '0; i_sample_y = '0; i_sample_z = '0; i_cfg_angle_limit = '0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; done = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zeros, extremes, pure axes, most negative x
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sh7fff, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sh7fff, 16'sd0);
        send_sample(16'sd0, 16'sh8000, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sh7fff);
        send_sample(16'sd0, 16'sd0, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sd1, 16'shffff, 16'sd8192);
        send_sample(16'sd4096, 16'sd4096, 16'sd0);
        send_sample(16'shffff, 16'sd1, 16'sd0);
        send_sample(16'h5555, 16'haaaa, 16'h5555);
        send_sample(16'haaaa, 16'h5555, 16'haaaa);
        drain();

        // Random phases across limits and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            write_limit(limits[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 0) hold_off = 200;
            for (int n = 0; n < 173; n++) random_sample();
            drain();
        end
        done = 1;
    end

    initial begin
        wait (done);
        if (sb.errors == 0 && sb.want_roll.size() == 0)
            $display("accel_tilt_angles regression: pass");
        else
            $display("accel_tilt_angles regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("accel_tilt_angles regression: fail");
        $finish;
    end
endmodule
